FILE: design/alpt_pkg.sv
// alpt_pkg: shared types and constants for the audio level and pitch tracker.
// No dependencies; used by alpt_csu and audio_level_and_pitch_tracker_top.
package alpt_pkg;

  // Configuration register indexes
  localparam logic [1:0] RegBlockSize  = 2'd0;
  localparam logic [1:0] RegSampleRate = 2'd1;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 18;

  // Field and state widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned BlkW    = 11;
  localparam int unsigned RateW   = 18;
  localparam int unsigned SumW    = 40;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned ToneW   = 20;

  // Shared multiplier operand widths
  localparam int unsigned MulAW = 20;
  localparam int unsigned MulBW = 18;
  localparam int unsigned ProdW = MulAW + MulBW;

  // Iterative compare-subtract unit
  localparam int unsigned OpW      = 40;
  localparam int unsigned WorkW    = OpW + 2;
  localparam int unsigned RemW     = 24;
  localparam int unsigned CntW     = 6;
  localparam int unsigned DivSteps  = OpW;
  localparam int unsigned RootSteps = WorkW / 2;

  // Reset values of the registers
  localparam logic [BlkW-1:0]  BlockSizeRst  = 11'd256;
  localparam logic [RateW-1:0] SampleRateRst = 18'd44100;

  // Smoothing coefficients, Q0.16; each pair sums to 1.0
  localparam logic [15:0] FastOld = 16'd58982;
  localparam logic [15:0] FastNew = 16'd6554;
  localparam logic [15:0] SlowOld = 16'd64881;
  localparam logic [15:0] SlowNew = 16'd655;

  localparam logic [ToneW-1:0] LevelMax = 20'h0FFFF;
  localparam logic [ToneW-1:0] ToneMax  = 20'hFFFFF;

  // Start request to the compare-subtract unit
  typedef struct packed {
    logic start;
    logic root;   // 1: square root of operand*4, 0: operand / divisor
  } csu_ctl_t;

endpackage

FILE: design/alpt_csu.sv
// alpt_csu: iterative compare-subtract unit, one quotient or root bit a cycle.
// Does restoring division by an 11-bit divisor and floor sqrt of operand*4.
// Depends on alpt_pkg.
module alpt_csu (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  alpt_pkg::csu_ctl_t               ctl_i,
  input  logic [alpt_pkg::OpW-1:0]         op_i,
  input  logic [alpt_pkg::BlkW-1:0]        div_i,
  output logic                             done_o,
  output logic [alpt_pkg::OpW-1:0]         res_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic                          root_q, root_d;
  logic [alpt_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [alpt_pkg::WorkW-1:0]    work_q, work_d;
  logic [alpt_pkg::RemW-1:0]     rem_q, rem_d;
  logic [alpt_pkg::OpW-1:0]      quo_q, quo_d;

  logic [alpt_pkg::RemW-1:0]     rem_sh;
  logic [alpt_pkg::RemW-1:0]     trial;
  logic [alpt_pkg::RemW:0]       diff;
  logic                          fits;

  // Shared shift / compare / subtract
  always_comb begin
    if (root_q) begin
      rem_sh = {rem_q[alpt_pkg::RemW-3:0], work_q[alpt_pkg::WorkW-1 -: 2]};
      trial  = {quo_q[alpt_pkg::RemW-3:0], 2'b01};
    end else begin
      rem_sh = {rem_q[alpt_pkg::RemW-2:0], work_q[alpt_pkg::WorkW-1]};
      trial  = alpt_pkg::RemW'(div_i);
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    fits = !diff[alpt_pkg::RemW];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    root_d = root_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (!busy_q) begin
      if (ctl_i.start) begin
        busy_d = 1'b1;
        root_d = ctl_i.root;
        cnt_d  = ctl_i.root ? alpt_pkg::CntW'(alpt_pkg::RootSteps - 1)
                            : alpt_pkg::CntW'(alpt_pkg::DivSteps - 1);
        work_d = {op_i, 2'b00};
        rem_d  = '0;
        quo_d  = '0;
      end
    end else begin
      rem_d  = fits ? diff[alpt_pkg::RemW-1:0] : rem_sh;
      quo_d  = {quo_q[alpt_pkg::OpW-2:0], fits};
      work_d = root_q ? {work_q[alpt_pkg::WorkW-3:0], 2'b00}
                      : {work_q[alpt_pkg::WorkW-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      root_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

FILE: design/audio_level_and_pitch_tracker_top.sv
// audio_level_and_pitch_tracker_top: block rms and zero-crossing pitch with
// fast and slow exponential smoothing. Depends on alpt_pkg and alpt_csu.
//
//  channel | handshake               | word
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid_i / in_stall_o | sample_i
//  out     | out_valid_o/out_stall_i | level_fast_o level_slow_o tone_fast_o
//          |                         | tone_slow_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// A sample word is accepted, squared on the shared multiplier and added with
// saturation to the sum. The last sample of a block goes on to the mean
// (start, 40 divide steps, pickup), the 21-step root, the pitch (product,
// start, divide), smoothing of the four averages on the multiplier and the
// load of the output register once it is free.
// Reset (async, active low) clears the block state and all averages and
// loads block_size 256 and sample_rate 44100. in_stall_o is high whenever the
// sequencer is busy; at block end it also holds while the new result waits for
// the output register to be taken.
module audio_level_and_pitch_tracker_top #(
  parameter int unsigned MAX_BLOCK = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [alpt_pkg::SampleW-1:0] sample_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [alpt_pkg::LevelW-1:0]       level_fast_o,
  output logic [alpt_pkg::LevelW-1:0]       level_slow_o,
  output logic [alpt_pkg::ToneW-1:0]        tone_fast_o,
  output logic [alpt_pkg::ToneW-1:0]        tone_slow_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [alpt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [alpt_pkg::CfgDatW-1:0]      cfg_data_i
);

  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] StIdle  = 4'd0;
  localparam logic [StW-1:0] StSq    = 4'd1;
  localparam logic [StW-1:0] StAcc   = 4'd2;
  localparam logic [StW-1:0] StMean  = 4'd3;
  localparam logic [StW-1:0] StMeanW = 4'd4;
  localparam logic [StW-1:0] StRootW = 4'd5;
  localparam logic [StW-1:0] StTMul  = 4'd6;
  localparam logic [StW-1:0] StTDiv  = 4'd7;
  localparam logic [StW-1:0] StTDivW = 4'd8;
  localparam logic [StW-1:0] StSmA   = 4'd9;
  localparam logic [StW-1:0] StSmB   = 4'd10;
  localparam logic [StW-1:0] StSmC   = 4'd11;
  localparam logic [StW-1:0] StOut   = 4'd12;

  localparam int unsigned SumAddW = alpt_pkg::ProdW;

  // config
  logic [alpt_pkg::BlkW-1:0]  block_size_q;
  logic [alpt_pkg::RateW-1:0] sample_rate_q;

  // sequencer and block state
  logic [StW-1:0]               state_q, state_d;
  logic [alpt_pkg::SumW-1:0]    sum_q, sum_d;
  logic [alpt_pkg::BlkW-1:0]    seen_q, seen_d;
  logic [alpt_pkg::BlkW-1:0]    cross_q, cross_d;
  logic                         prior_pos_q, prior_pos_d;
  logic [alpt_pkg::SampleW-1:0] mag_q, mag_d;
  logic [1:0]                   sm_q, sm_d;

  // averages
  logic [alpt_pkg::LevelW-1:0]  lvl_fast_q, lvl_fast_d;
  logic [alpt_pkg::LevelW-1:0]  lvl_slow_q, lvl_slow_d;
  logic [alpt_pkg::ToneW-1:0]   tone_fast_q, tone_fast_d;
  logic [alpt_pkg::ToneW-1:0]   tone_slow_q, tone_slow_d;

  // block results
  logic [alpt_pkg::LevelW-1:0]  rms_q, rms_d;
  logic [alpt_pkg::ToneW-1:0]   tone_q, tone_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [alpt_pkg::LevelW-1:0]  out_lf_q, out_ls_q;
  logic [alpt_pkg::ToneW-1:0]   out_tf_q, out_ts_q;
  logic                         out_load;

  // shared multiplier
  logic [alpt_pkg::MulAW-1:0]   mul_a;
  logic [alpt_pkg::MulBW-1:0]   mul_b;
  logic [alpt_pkg::ProdW-1:0]   prod_q, prod_d;
  logic [alpt_pkg::ProdW-1:0]   part_q, part_d;

  // compare-subtract unit
  alpt_pkg::csu_ctl_t           csu_ctl;
  logic [alpt_pkg::OpW-1:0]     csu_op;
  logic                         csu_done;
  logic [alpt_pkg::OpW-1:0]     csu_res;

  logic [alpt_pkg::BlkW-1:0]    n_eff;
  logic                         in_acc;
  logic                         pos;
  logic [alpt_pkg::SumW:0]      sum_add;
  logic [alpt_pkg::OpW-1:0]     tone_num;
  logic [alpt_pkg::ToneW-1:0]   sm_acc, sm_x, sm_top;
  logic [15:0]                  coef_old, coef_new;
  logic [SumAddW:0]             sm_sum;
  logic [SumAddW-16:0]          sm_t;
  logic [alpt_pkg::ToneW-1:0]   sm_res;

  // ---------------------------------------------------------------------
  // Register writes: always accepted; user must write only when the block is idle.
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= alpt_pkg::BlockSizeRst;
      sample_rate_q <= alpt_pkg::SampleRateRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        alpt_pkg::RegBlockSize:  block_size_q  <= cfg_data_i[alpt_pkg::BlkW-1:0];
        alpt_pkg::RegSampleRate: sample_rate_q <= cfg_data_i[alpt_pkg::RateW-1:0];
        default: ;
      endcase
    end
  end

  // Effective block length: zero means 1, clamp to MAX_BLOCK.
  always_comb begin
    if (block_size_q == '0) begin
      n_eff = alpt_pkg::BlkW'(1);
    end else if (32'(block_size_q) > MAX_BLOCK) begin
      n_eff = alpt_pkg::BlkW'(MAX_BLOCK);
    end else begin
      n_eff = block_size_q;
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  // zero counts as not positive
  assign pos        = (sample_i != '0) && !sample_i[alpt_pkg::SampleW-1];

  // ---------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------
  always_comb begin
    case (sm_q)
      2'd0: begin
        sm_acc = alpt_pkg::ToneW'(lvl_fast_q);
        sm_x   = alpt_pkg::ToneW'(rms_q);
      end
      2'd1: begin
        sm_acc = alpt_pkg::ToneW'(lvl_slow_q);
        sm_x   = alpt_pkg::ToneW'(rms_q);
      end
      2'd2: begin
        sm_acc = tone_fast_q;
        sm_x   = tone_q;
      end
      default: begin
        sm_acc = tone_slow_q;
        sm_x   = tone_q;
      end
    endcase
    coef_old = sm_q[0] ? alpt_pkg::SlowOld : alpt_pkg::FastOld;
    coef_new = sm_q[0] ? alpt_pkg::SlowNew : alpt_pkg::FastNew;
    sm_top   = sm_q[1] ? alpt_pkg::ToneMax : alpt_pkg::LevelMax;
  end

  always_comb begin
    case (state_q)
      StSq: begin
        mul_a = alpt_pkg::MulAW'(mag_q);
        mul_b = alpt_pkg::MulBW'(mag_q);
      end
      StTMul: begin
        mul_a = alpt_pkg::MulAW'(cross_q);
        mul_b = sample_rate_q;
      end
      StSmA: begin
        mul_a = sm_acc;
        mul_b = alpt_pkg::MulBW'(coef_old);
      end
      StSmB: begin
        mul_a = sm_x;
        mul_b = alpt_pkg::MulBW'(coef_new);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = alpt_pkg::ProdW'(mul_a) * alpt_pkg::ProdW'(mul_b);
  end

  // saturating square accumulate (a square is at most 2^30)
  assign sum_add  = {1'b0, sum_q} + (alpt_pkg::SumW + 1)'(prod_q[31:0]);
  // crossings*rate*8 + floor(N/2); crossings*rate fits 29 bits
  assign tone_num = alpt_pkg::OpW'({prod_q[28:0], 3'b000})
                  + alpt_pkg::OpW'(n_eff[alpt_pkg::BlkW-1:1]);

  // (a*acc + b*x + 0.5) >> 16, saturated to the average's width
  assign sm_sum = {1'b0, part_q} + {1'b0, prod_q} + (SumAddW + 1)'(32768);
  assign sm_t   = sm_sum[SumAddW:16];
  assign sm_res = (sm_t > (SumAddW - 15)'(sm_top)) ? sm_top : sm_t[alpt_pkg::ToneW-1:0];

  assign out_load = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    cross_d     = cross_q;
    prior_pos_d = prior_pos_q;
    mag_d       = mag_q;
    sm_d        = sm_q;
    lvl_fast_d  = lvl_fast_q;
    lvl_slow_d  = lvl_slow_q;
    tone_fast_d = tone_fast_q;
    tone_slow_d = tone_slow_q;
    rms_d       = rms_q;
    tone_d      = tone_q;
    part_d      = part_q;
    csu_ctl     = '0;
    csu_op      = sum_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          mag_d       = sample_i[alpt_pkg::SampleW-1] ? alpt_pkg::SampleW'(-sample_i)
                                                      : alpt_pkg::SampleW'(sample_i);
          if (pos != prior_pos_q) begin
            cross_d = cross_q + 1'b1;
          end
          prior_pos_d = pos;
          seen_d      = seen_q + 1'b1;
          state_d     = StSq;
        end
      end
      StSq: begin
        state_d = StAcc;
      end
      StAcc: begin
        sum_d   = sum_add[alpt_pkg::SumW] ? '1 : sum_add[alpt_pkg::SumW-1:0];
        state_d = (seen_q >= n_eff) ? StMean : StIdle;
      end
      StMean: begin
        csu_ctl.start = 1'b1;
        csu_op        = sum_q;
        state_d       = StMeanW;
      end
      StMeanW: begin
        if (csu_done) begin
          csu_ctl.start = 1'b1;
          csu_ctl.root  = 1'b1;
          csu_op        = csu_res;
          state_d       = StRootW;
        end
      end
      StRootW: begin
        if (csu_done) begin
          rms_d   = (|csu_res[alpt_pkg::OpW-1:alpt_pkg::LevelW]) ? '1
                  : csu_res[alpt_pkg::LevelW-1:0];
          state_d = StTMul;
        end
      end
      StTMul: begin
        state_d = StTDiv;
      end
      StTDiv: begin
        csu_ctl.start = 1'b1;
        csu_op        = tone_num;
        state_d       = StTDivW;
      end
      StTDivW: begin
        if (csu_done) begin
          tone_d  = (|csu_res[alpt_pkg::OpW-1:alpt_pkg::ToneW]) ? '1
                  : csu_res[alpt_pkg::ToneW-1:0];
          sum_d   = '0;
          seen_d  = '0;
          cross_d = '0;
          sm_d    = 2'd0;
          state_d = StSmA;
        end
      end
      StSmA: begin
        state_d = StSmB;
      end
      StSmB: begin
        part_d  = prod_q;
        state_d = StSmC;
      end
      StSmC: begin
        case (sm_q)
          2'd0:    lvl_fast_d  = sm_res[alpt_pkg::LevelW-1:0];
          2'd1:    lvl_slow_d  = sm_res[alpt_pkg::LevelW-1:0];
          2'd2:    tone_fast_d = sm_res;
          default: tone_slow_d = sm_res;
        endcase
        sm_d    = sm_q + 1'b1;
        state_d = (sm_q == 2'd3) ? StOut : StSmA;
      end
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      seen_q      <= '0;
      cross_q     <= '0;
      prior_pos_q <= 1'b0;
      sm_q        <= '0;
      lvl_fast_q  <= '0;
      lvl_slow_q  <= '0;
      tone_fast_q <= '0;
      tone_slow_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      cross_q     <= cross_d;
      prior_pos_q <= prior_pos_d;
      sm_q        <= sm_d;
      lvl_fast_q  <= lvl_fast_d;
      lvl_slow_q  <= lvl_slow_d;
      tone_fast_q <= tone_fast_d;
      tone_slow_q <= tone_slow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    prod_q <= prod_d;
    part_q <= part_d;
    rms_q  <= rms_d;
    tone_q <= tone_d;
  end

  // ---------------------------------------------------------------------
  // Output register: loaded only when empty or being taken
  // ---------------------------------------------------------------------
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lf_q <= lvl_fast_q;
      out_ls_q <= lvl_slow_q;
      out_tf_q <= tone_fast_q;
      out_ts_q <= tone_slow_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign level_fast_o = out_lf_q;
  assign level_slow_o = out_ls_q;
  assign tone_fast_o  = out_tf_q;
  assign tone_slow_o  = out_ts_q;

  alpt_csu u_csu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (csu_ctl),
    .op_i   (csu_op),
    .div_i  (n_eff),
    .done_o (csu_done),
    .res_o  (csu_res)
  );

endmodule
